### rtl/cva_pkg.sv
package cva_pkg;

  // Binary expansions with 96 fractional bits: pi/4, and the fraction of pi.
  localparam logic [95:0] QPI_FRAC = 96'hC90FDAA22168C234C4C6628B;
  localparam logic [95:0] PI_FRAC  = 96'h243F6A8885A308D313198A2E;

  // Inverse CORDIC gain, round(Kinv * 2^64).
  localparam logic [63:0] KINV = 64'h9B74EDA8435E5A68;

  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
  } cva_flags_t;

  // Restoring division by a small odd divisor, elaboration only.
  function automatic logic [63:0] udiv_small(input logic [63:0] num, input logic [6:0] d);
    logic [7:0]  rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[6:0], num[b]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-idx) at scale 2^64 from the alternating series, each term rounded.
  function automatic logic [63:0] atan_raw(input int idx);
    logic [63:0] t;
    logic [63:0] num;
    logic [63:0] term;
    int          m;
    int          e;
    t = '0;
    for (int k = 0; k < 32; k++) begin
      m = 2 * k + 1;
      e = 64 - idx * m;
      if (e >= 0) begin
        num  = (64'd1 << e) + 64'(m >> 1);
        term = udiv_small(num, 7'(m));
        if ((k & 1) != 0) t = t - term;
        else              t = t + term;
      end
    end
    return t;
  endfunction

  // Angle step for one iteration, rounded half up to frac fractional bits.
  function automatic logic [63:0] angle_entry(input int idx, input int frac);
    logic [96:0] q;
    logic [64:0] t;
    if (idx == 0) begin
      q = {1'b0, QPI_FRAC} + (97'd1 << (95 - frac));
      return 64'(q >> (96 - frac));
    end
    t = {1'b0, atan_raw(idx)} + (65'd1 << (63 - frac));
    return 64'(t >> (64 - frac));
  endfunction

  function automatic logic [63:0] pi_fixed(input int frac);
    logic [96:0] q;
    q = {1'b0, PI_FRAC} + (97'd1 << (95 - frac));
    return (64'd3 << frac) + 64'(q >> (96 - frac));
  endfunction

endpackage

### rtl/cva_prep.sv
module cva_prep #(
  parameter int WIDTH = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic signed [WIDTH-1:0]   y_in,
  input  logic signed [WIDTH-1:0]   x_in,
  output cva_pkg::cva_flags_t       flags_out,
  output logic signed [WIDTH+2:0]   x_out,
  output logic signed [WIDTH+2:0]   y_out
);
  import cva_pkg::*;

  localparam int XW = WIDTH + 3;
  localparam logic [WIDTH-1:0] MIN_CODE = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MAX_CODE = {1'b0, {(WIDTH-1){1'b1}}};

  cva_flags_t           flags_r;
  logic signed [XW-1:0] x_r;
  logic signed [XW-1:0] y_r;
  logic [WIDTH-1:0]     ax;
  logic [WIDTH-1:0]     ay;

  // Most negative code saturates to the most positive one.
  always_comb begin
    if (!x_in[WIDTH-1])        ax = x_in;
    else if (x_in == MIN_CODE) ax = MAX_CODE;
    else                       ax = -x_in;
    if (!y_in[WIDTH-1])        ay = y_in;
    else if (y_in == MIN_CODE) ay = MAX_CODE;
    else                       ay = -y_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= '{valid: accept, neg_x: x_in[WIDTH-1], neg_y: y_in[WIDTH-1]};
    end
  end

  always_ff @(posedge clk) begin
    x_r <= {3'b000, ax};
    y_r <= {3'b000, ay};
  end

  assign flags_out = flags_r;
  assign x_out     = x_r;
  assign y_out     = y_r;

endmodule

### rtl/cva_stage.sv
module cva_stage #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 28,
  parameter int IDX       = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [6:0]              n_iter,
  input  cva_pkg::cva_flags_t     flags_in,
  input  logic signed [WIDTH+2:0] x_in,
  input  logic signed [WIDTH+2:0] y_in,
  input  logic signed [((FRAC_BITS+4 > WIDTH+1) ? FRAC_BITS+4 : WIDTH+1)-1:0] z_in,
  output cva_pkg::cva_flags_t     flags_out,
  output logic signed [WIDTH+2:0] x_out,
  output logic signed [WIDTH+2:0] y_out,
  output logic signed [((FRAC_BITS+4 > WIDTH+1) ? FRAC_BITS+4 : WIDTH+1)-1:0] z_out
);
  import cva_pkg::*;

  localparam int XW = WIDTH + 3;
  localparam int ZW = (FRAC_BITS + 4 > WIDTH + 1) ? FRAC_BITS + 4 : WIDTH + 1;
  localparam logic [63:0]          ANG64 = angle_entry(IDX, FRAC_BITS);
  localparam logic signed [ZW-1:0] ANG   = ZW'(ANG64);
  localparam logic [6:0]           IDX7  = 7'(IDX);

  cva_flags_t           flags_r;
  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    xs    = x_in >>> IDX;
    ys    = y_in >>> IDX;
    x_nxt = x_in;
    y_nxt = y_in;
    z_nxt = z_in;
    // Pass the item through once the configured count is used up.
    if (n_iter > IDX7) begin
      if (!y_in[XW-1]) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + ANG;
      end else begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else begin
      flags_r <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign flags_out = flags_r;
  assign x_out     = x_r;
  assign y_out     = y_r;
  assign z_out     = z_r;

endmodule

### rtl/cva_post.sv
module cva_post #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cva_pkg::cva_flags_t     flags_in,
  input  logic signed [WIDTH+2:0] x_in,
  input  logic signed [((FRAC_BITS+4 > WIDTH+1) ? FRAC_BITS+4 : WIDTH+1)-1:0] z_in,
  output logic                    valid_out,
  output logic signed [WIDTH-1:0] magnitude_out,
  output logic signed [WIDTH-1:0] angle_out
);
  import cva_pkg::*;

  localparam int XW = WIDTH + 3;
  localparam int ZW = (FRAC_BITS + 4 > WIDTH + 1) ? FRAC_BITS + 4 : WIDTH + 1;
  localparam int NC = (XW - 1 + 31) / 32;
  localparam int MW = NC * 32;
  localparam int PW = MW + 64;

  localparam logic [63:0]          PI64    = pi_fixed(FRAC_BITS);
  localparam logic signed [ZW-1:0] PI_Z    = ZW'(PI64);
  localparam logic signed [ZW-1:0] ANG_MAX = {{(ZW-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};
  localparam logic signed [ZW-1:0] ANG_MIN = ~ANG_MAX;
  localparam logic [MW-1:0]        MAG_MAX = {{(MW-WIDTH+1){1'b0}}, {(WIDTH-1){1'b1}}};

  // Stage 1: 32x32 partial products of x and the gain constant.
  cva_flags_t           f1_r;
  logic                 xneg1_r;
  logic signed [ZW-1:0] z1_r;
  logic [63:0]          pp_r [NC][2];
  logic [MW-1:0]        xpad;

  // Stage 2: one row per x chunk; quadrant correction of the angle.
  cva_flags_t           f2_r;
  logic                 xneg2_r;
  logic signed [ZW-1:0] z2_r, z2_nxt;
  logic [95:0]          row_r [NC];

  // Stage 3: final sum, rounding, sign of the angle and saturation.
  logic                 valid_r;
  logic [WIDTH-1:0]     mag_r, mag_nxt;
  logic [WIDTH-1:0]     ang_r, ang_nxt;
  logic [PW-1:0]        acc;
  logic [MW-1:0]        mag_full;
  logic signed [ZW-1:0] zn;

  assign xpad = MW'(x_in[XW-2:0]);

  always_ff @(posedge clk) begin
    for (int j = 0; j < NC; j++) begin
      for (int h = 0; h < 2; h++) begin
        pp_r[j][h] <= {32'b0, xpad[32*j +: 32]} * {32'b0, KINV[32*h +: 32]};
      end
    end
    xneg1_r <= x_in[XW-1];
    z1_r    <= z_in;
  end

  assign z2_nxt = f1_r.neg_x ? PI_Z - z1_r : z1_r;

  always_ff @(posedge clk) begin
    for (int j = 0; j < NC; j++) begin
      row_r[j] <= {32'b0, pp_r[j][0]} + {pp_r[j][1], 32'b0};
    end
    xneg2_r <= xneg1_r;
    z2_r    <= z2_nxt;
  end

  always_comb begin
    // Round half up before dropping the 64 fraction bits of the gain.
    acc = PW'(1) << 63;
    for (int j = 0; j < NC; j++) begin
      acc = acc + (PW'(row_r[j]) << (32 * j));
    end
    mag_full = acc[PW-1:64];
    if (xneg2_r)                mag_nxt = '0;
    else if (mag_full > MAG_MAX) mag_nxt = MAG_MAX[WIDTH-1:0];
    else                         mag_nxt = mag_full[WIDTH-1:0];

    zn = f2_r.neg_y ? -z2_r : z2_r;
    if (zn > ANG_MAX)      ang_nxt = ANG_MAX[WIDTH-1:0];
    else if (zn < ANG_MIN) ang_nxt = ANG_MIN[WIDTH-1:0];
    else                   ang_nxt = zn[WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    ang_r <= ang_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r    <= '0;
      f2_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      f1_r    <= flags_in;
      f2_r    <= f1_r;
      valid_r <= f2_r.valid;
    end
  end

  assign valid_out     = valid_r;
  assign magnitude_out = mag_r;
  assign angle_out     = ang_r;

endmodule

### rtl/cordic_vectoring_atan2_top.sv
// Pipeline: one input register, WIDTH unrolled iteration stages and three gain/angle
// stages lie between the start edge and the edge that takes the result strobe.
// Throughput: one item per clock; busy is low except through reset and the cycle after.
// The result cannot be stalled, so the pipeline advances every cycle.
// Synchronous active-low reset clears all valid bits and sets iterations to 32.
module cordic_vectoring_atan2_top #(
  parameter int WIDTH     = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] in_y_in,
  input  logic signed [WIDTH-1:0] in_x_in,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [5:0]              cfg_iterations,
  output logic                    out_valid,
  output logic signed [WIDTH-1:0] out_magnitude,
  output logic signed [WIDTH-1:0] out_angle
);
  import cva_pkg::*;

  localparam int XW = WIDTH + 3;
  localparam int ZW = (FRAC_BITS + 4 > WIDTH + 1) ? FRAC_BITS + 4 : WIDTH + 1;
  localparam logic [5:0] ITER_RESET = 6'd32;
  localparam logic [6:0] W7         = 7'(WIDTH);

  logic                 busy_r;
  logic [5:0]           iter_r;
  logic [6:0]           n_iter;
  logic                 accept;

  cva_flags_t           f_s [WIDTH+1];
  logic signed [XW-1:0] x_s [WIDTH+1];
  logic signed [XW-1:0] y_s [WIDTH+1];
  logic signed [ZW-1:0] z_s [WIDTH+1];

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign n_iter    = ({1'b0, iter_r} > W7) ? W7 : {1'b0, iter_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      iter_r <= ITER_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) iter_r <= cfg_iterations;
    end
  end

  cva_prep #(.WIDTH(WIDTH)) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .y_in      (in_y_in),
    .x_in      (in_x_in),
    .flags_out (f_s[0]),
    .x_out     (x_s[0]),
    .y_out     (y_s[0])
  );

  assign z_s[0] = '0;

  for (genvar i = 0; i < WIDTH; i++) begin : g_iter
    cva_stage #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS), .IDX(i)) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .n_iter    (n_iter),
      .flags_in  (f_s[i]),
      .x_in      (x_s[i]),
      .y_in      (y_s[i]),
      .z_in      (z_s[i]),
      .flags_out (f_s[i+1]),
      .x_out     (x_s[i+1]),
      .y_out     (y_s[i+1]),
      .z_out     (z_s[i+1])
    );
  end

  cva_post #(.WIDTH(WIDTH), .FRAC_BITS(FRAC_BITS)) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .flags_in      (f_s[WIDTH]),
    .x_in          (x_s[WIDTH]),
    .z_in          (z_s[WIDTH]),
    .valid_out     (out_valid),
    .magnitude_out (out_magnitude),
    .angle_out     (out_angle)
  );

  // The first stage holds an item exactly when one was taken on the previous edge.
  a_prep_tracks_accept: assert property (@(posedge clk) disable iff (!rst_n)
    f_s[0].valid == $past(start && !busy && rst_n))
    else $error("input stage valid does not match accepted item");

  a_mag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_magnitude[WIDTH-1])
    else $error("negative magnitude on result");

endmodule
